### rtl/core/eapd_pkg.sv
// Shared widths, constants and types of the encoder angle PID drive.
`default_nettype none

package eapd_pkg;

    // Field widths
    localparam int COUNT_W    = 16;
    localparam int ANGLE_W    = 15;
    localparam int ERR_W      = 16;
    localparam int DRIVE_W    = 20;
    localparam int TARGET_W   = 15;
    localparam int GAIN_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Default accumulator width
    localparam int SUM_W_DEF = 24;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // Divide by ten: floor(x * 52429 / 2^19) is exact for 0 <= x <= 32768
    localparam int            RECIP_W     = 17;
    localparam logic [16:0]   RECIP_10    = 17'd52429;
    localparam int            RECIP_SHIFT = 19;
    localparam int            QUO_W       = 12;
    localparam int            AMAG_W      = 14;

    // Fixed-point scaling of the drive law
    localparam int ROUND_BIAS  = 128;
    localparam int SCALE_SHIFT = 8;
    localparam int TRUNC_BIAS  = (1 << SCALE_SHIFT) - 1;

    localparam logic signed [TARGET_W-1:0] TARGET_RESET = 15'sd90;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_PROP   = 2'd1,
        CFG_INTEG  = 2'd2,
        CFG_DERIV  = 2'd3
    } t_cfg_idx;

    // Classified sample handed from front to back
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [ERR_W-1:0]   angle_error;
    } t_front_beat;

    // Loop gains
    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } t_gains;

endpackage

`default_nettype wire

### rtl/core/eapd_in_if.sv
// Sample channel: valid, ready and the encoder count.
`default_nettype none

interface eapd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [eapd_pkg::COUNT_W-1:0]  encoder_count;

    modport source (output valid, output encoder_count, input ready);
    modport sink   (input valid, input encoder_count, output ready);
endinterface

`default_nettype wire

### rtl/core/eapd_out_if.sv
// Result channel: valid, ready, drive, angle and angle error.
`default_nettype none

interface eapd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [eapd_pkg::DRIVE_W-1:0]  drive;
    logic signed [eapd_pkg::ANGLE_W-1:0]  angle;
    logic signed [eapd_pkg::ERR_W-1:0]    angle_error;

    modport source (output valid, output drive, output angle, output angle_error, input ready);
    modport sink   (input valid, input drive, input angle, input angle_error, output ready);
endinterface

`default_nettype wire

### rtl/core/eapd_front.sv
// Front part: takes encoder counts and turns them into angle and error.
`default_nettype none

module eapd_front (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    eapd_in_if.sink                                     i_sample,
    input  wire logic signed [eapd_pkg::TARGET_W-1:0]   i_target,
    output logic                                        o_beat_valid,
    input  wire logic                                   i_beat_ready,
    output eapd_pkg::t_front_beat                       o_beat
);

    localparam int PROD_W = eapd_pkg::COUNT_W + eapd_pkg::RECIP_W;

    logic                              r_a_valid;
    logic                              r_a_neg;
    logic [eapd_pkg::QUO_W-1:0]        r_a_quo;
    logic                              r_b_valid;
    eapd_pkg::t_front_beat             r_b_beat;

    logic                              a_ready;
    logic                              b_ready;
    logic [eapd_pkg::COUNT_W-1:0]      count_mag;
    logic [PROD_W-1:0]                 quo_prod;
    logic [eapd_pkg::AMAG_W-1:0]       angle_mag;
    logic signed [eapd_pkg::ANGLE_W-1:0] angle;

    // Elastic handshake along the two stages
    assign b_ready        = !r_b_valid || i_beat_ready;
    assign a_ready        = !r_a_valid || b_ready;
    assign i_sample.ready = a_ready;

    // Stage A: magnitude divided by ten through the reciprocal
    assign count_mag = i_sample.encoder_count[eapd_pkg::COUNT_W-1]
                     ? eapd_pkg::COUNT_W'(-i_sample.encoder_count)
                     : eapd_pkg::COUNT_W'(i_sample.encoder_count);
    assign quo_prod  = PROD_W'(count_mag) * PROD_W'(eapd_pkg::RECIP_10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_sample.valid) begin
            r_a_neg <= i_sample.encoder_count[eapd_pkg::COUNT_W-1];
            r_a_quo <= quo_prod[eapd_pkg::RECIP_SHIFT +: eapd_pkg::QUO_W];
        end
    end

    // Stage B: times three, restore sign, subtract from the target
    assign angle_mag = eapd_pkg::AMAG_W'({r_a_quo, 1'b0}) + eapd_pkg::AMAG_W'(r_a_quo);
    assign angle     = r_a_neg ? -$signed({1'b0, angle_mag}) : $signed({1'b0, angle_mag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_beat.angle       <= angle;
            r_b_beat.angle_error <= eapd_pkg::ERR_W'(i_target) - eapd_pkg::ERR_W'(angle);
        end
    end

    assign o_beat_valid = r_b_valid;
    assign o_beat       = r_b_beat;

endmodule

`default_nettype wire

### rtl/core/eapd_queue.sv
// Short queue that decouples the front and back parts.
`default_nettype none

module eapd_queue (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push_valid,
    output logic                          o_push_ready,
    input  wire eapd_pkg::t_front_beat    i_push_beat,
    output logic                          o_pop_valid,
    input  wire logic                     i_pop_ready,
    output eapd_pkg::t_front_beat         o_pop_beat
);

    localparam int DEPTH = eapd_pkg::QUEUE_DEPTH;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    eapd_pkg::t_front_beat   r_mem [DEPTH];
    logic [IDX_W-1:0]        r_wr_ptr;
    logic [IDX_W-1:0]        r_rd_ptr;
    logic [CNT_W-1:0]        r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_beat   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_beat;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/eapd_back.sv
// Back part: accumulator, error difference and the PID drive pipeline.
`default_nettype none

module eapd_back #(
    parameter int SUM_WIDTH = eapd_pkg::SUM_W_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_beat_valid,
    output logic                          o_beat_ready,
    input  wire eapd_pkg::t_front_beat    i_beat,
    input  wire eapd_pkg::t_gains         i_gains,
    eapd_out_if.source                    o_result
);

    localparam int SW   = SUM_WIDTH;
    localparam int EW   = eapd_pkg::ERR_W;
    localparam int DW   = EW + 1;                    // error difference
    localparam int GW   = eapd_pkg::GAIN_W + 1;      // gain as signed operand
    localparam int PEW  = GW + EW + 1;
    localparam int PDW  = GW + DW + 1;
    localparam int PIW  = GW + SW + 1;
    localparam int XW   = PIW + 1;
    localparam int QIW  = XW - eapd_pkg::SCALE_SHIFT;
    localparam int PPW  = PDW + 1;
    localparam int TW   = (SW + 6 > 31) ? SW + 6 : 31;
    localparam int RW   = TW - eapd_pkg::SCALE_SHIFT;
    localparam int VW   = RW + 1;
    localparam int OW   = eapd_pkg::DRIVE_W;

    // Accumulator and previous error
    logic signed [SW-1:0]    r_sum;
    logic signed [EW-1:0]    r_prev;

    // Pipeline valid bits and payload
    logic                    r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r_out_valid;
    eapd_pkg::t_front_beat   r1_beat, r2_beat, r3_beat, r4_beat, r5_beat;
    logic signed [DW-1:0]    r1_d;
    logic signed [SW-1:0]    r1_s;
    logic                    r2_neg, r3_neg, r4_neg, r5_neg;
    logic signed [EW:0]      r2_ae;
    logic signed [DW:0]      r2_ad;
    logic signed [SW:0]      r2_as;
    logic signed [PEW-1:0]   r3_pe;
    logic signed [PDW-1:0]   r3_pd;
    logic signed [PIW-1:0]   r3_pi;
    logic signed [QIW-1:0]   r4_qi;
    logic signed [PPW-1:0]   r4_pp;
    logic signed [RW-1:0]    r5_r;
    logic signed [OW-1:0]    r_out_drive;
    eapd_pkg::t_front_beat   r_out_beat;

    logic                    adv;
    logic                    take;
    logic signed [SW:0]      sum_ext;
    logic signed [SW-1:0]    sum_sat;
    logic signed [DW-1:0]    diff;
    logic                    neg;
    logic signed [EW:0]      e_ext;
    logic signed [DW:0]      d_ext;
    logic signed [SW:0]      s_ext;
    logic signed [GW-1:0]    kp, ki, kd;
    logic signed [XW-1:0]    x_int;
    logic signed [XW-1:0]    x_adj;
    logic signed [TW-1:0]    tot;
    logic signed [TW-1:0]    tot_adj;
    logic signed [VW-1:0]    v_drive;
    logic [VW-OW:0]          v_hi;
    logic signed [OW-1:0]    drive_sat;

    // Whole back pipeline moves when the output register is free or taken
    assign adv          = !r_out_valid || o_result.ready;
    assign o_beat_ready = adv;
    assign take         = adv && i_beat_valid;

    // Stage 1: saturating accumulate and error difference
    assign sum_ext = (SW + 1)'(r_sum) + (SW + 1)'(i_beat.angle_error);
    always_comb begin
        if (sum_ext[SW] != sum_ext[SW-1]) begin
            sum_sat = sum_ext[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SW-1:0];
        end
    end
    assign diff = DW'(i_beat.angle_error) - DW'(r_prev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (take) begin
            r_sum  <= sum_sat;
            r_prev <= i_beat.angle_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r1_beat <= i_beat;
            r1_d    <= diff;
            r1_s    <= sum_sat;
        end
    end

    // Stage 2: fold sign, magnitudes for non-positive error
    assign neg   = r1_beat.angle_error[EW-1] || (r1_beat.angle_error == '0);
    assign e_ext = (EW + 1)'(r1_beat.angle_error);
    assign d_ext = (DW + 1)'(r1_d);
    assign s_ext = (SW + 1)'(r1_s);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_beat <= r1_beat;
            r2_neg  <= neg;
            r2_ae   <= neg ? -e_ext : e_ext;
            r2_ad   <= (neg && r1_d[DW-1]) ? -d_ext : d_ext;
            r2_as   <= (neg && r1_s[SW-1]) ? -s_ext : s_ext;
        end
    end

    // Stage 3: the three gain products
    assign kp = $signed({1'b0, i_gains.prop});
    assign ki = $signed({1'b0, i_gains.integ});
    assign kd = $signed({1'b0, i_gains.deriv});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_beat <= r2_beat;
            r3_neg  <= r2_neg;
            r3_pe   <= PEW'(kp) * PEW'(r2_ae);
            r3_pd   <= PDW'(kd) * PDW'(r2_ad);
            r3_pi   <= PIW'(ki) * PIW'(r2_as);
        end
    end

    // Stage 4: round and truncate integral toward zero; add P and D terms
    assign x_int = XW'(r3_pi) + XW'(eapd_pkg::ROUND_BIAS);
    assign x_adj = x_int[XW-1] ? x_int + XW'(eapd_pkg::TRUNC_BIAS) : x_int;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_beat <= r3_beat;
            r4_neg  <= r3_neg;
            r4_qi   <= x_adj[XW-1:eapd_pkg::SCALE_SHIFT];
            r4_pp   <= PPW'(r3_pe) + PPW'(r3_pd);
        end
    end

    // Stage 5: total with rounding, scaled and truncated toward zero
    assign tot     = TW'(r4_pp) + TW'(r4_qi) + TW'(eapd_pkg::ROUND_BIAS);
    assign tot_adj = tot[TW-1] ? tot + TW'(eapd_pkg::TRUNC_BIAS) : tot;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_beat <= r4_beat;
            r5_neg  <= r4_neg;
            r5_r    <= tot_adj[TW-1:eapd_pkg::SCALE_SHIFT];
        end
    end

    // Output stage: restore sign and clamp to the drive range
    assign v_drive = r5_neg ? -VW'(r5_r) : VW'(r5_r);
    assign v_hi    = v_drive[VW-1:OW-1];
    always_comb begin
        if (&v_hi || ~|v_hi) begin
            drive_sat = v_drive[OW-1:0];
        end else if (v_drive[VW-1]) begin
            drive_sat = {1'b1, {(OW - 1){1'b0}}};
        end else begin
            drive_sat = {1'b0, {(OW - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_beat  <= r5_beat;
            r_out_drive <= drive_sat;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r1_valid    <= i_beat_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.drive       = r_out_drive;
    assign o_result.angle       = r_out_beat.angle;
    assign o_result.angle_error = r_out_beat.angle_error;

endmodule

`default_nettype wire

### rtl/core/encoder_angle_pid_drive.sv
// Encoder angle PID drive: top level with configuration registers.
//
// Usage: encoder counts enter on the i_sample channel (valid/ready); each
// accepted beat gives exactly one beat on o_result carrying the drive, the
// derived angle and the angle error, in input order. Target angle and the
// three gains are written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the block is idle; index 0 target, 1 proportional, 2 integral, 3
// derivative gain.
// Throughput: one sample per cycle sustained while o_result.ready stays
// high. A sample passes two front stages, one queue slot, five back
// stages and the output register; the first front stage loads at the
// accepting edge. The accumulator and previous-error update in the
// first back stage sets the rate.
// Reset: synchronous, active low; clears the accumulator and previous error
// to zero, the target to 90 and all gains to zero, and empties the pipeline.
// Receiver stall: the back pipeline and output register hold; the front and
// the two-entry queue keep taking samples until the queue and both front
// stages are full, then i_sample.ready drops.
`default_nettype none

module encoder_angle_pid_drive #(
    parameter int SUM_WIDTH = eapd_pkg::SUM_W_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    eapd_in_if.sink                                    i_sample,
    eapd_out_if.source                                 o_result,
    input  wire logic                                  i_cfg_we,
    input  wire logic [eapd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [eapd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic signed [eapd_pkg::TARGET_W-1:0]  r_target;
    eapd_pkg::t_gains                      r_gains;

    logic                                  front_valid;
    logic                                  front_ready;
    eapd_pkg::t_front_beat                 front_beat;
    logic                                  back_valid;
    logic                                  back_ready;
    eapd_pkg::t_front_beat                 back_beat;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= eapd_pkg::TARGET_RESET;
            r_gains.prop  <= '0;
            r_gains.integ <= '0;
            r_gains.deriv <= '0;
        end else if (i_cfg_we) begin
            unique case (eapd_pkg::t_cfg_idx'(i_cfg_idx))
                eapd_pkg::CFG_TARGET: r_target      <= $signed(i_cfg_data[eapd_pkg::TARGET_W-1:0]);
                eapd_pkg::CFG_PROP:   r_gains.prop  <= i_cfg_data[eapd_pkg::GAIN_W-1:0];
                eapd_pkg::CFG_INTEG:  r_gains.integ <= i_cfg_data[eapd_pkg::GAIN_W-1:0];
                eapd_pkg::CFG_DERIV:  r_gains.deriv <= i_cfg_data[eapd_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    eapd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_target     (r_target),
        .o_beat_valid (front_valid),
        .i_beat_ready (front_ready),
        .o_beat       (front_beat)
    );

    eapd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_beat  (front_beat),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_beat   (back_beat)
    );

    eapd_back #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (back_valid),
        .o_beat_ready (back_ready),
        .i_beat       (back_beat),
        .i_gains      (r_gains),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking encoder angle PID drive bench: directed table, random phases, saturation runs.
`timescale 1ns / 1ps

module tb;

    localparam int     CYCLE_LIMIT     = 1_000_000;
    localparam int     IDLE_PAD        = 12;
    localparam int     DRAIN_PAD       = 20;
    localparam int     DIR_ROWS        = 25;
    localparam int     MIXED_PHASES    = 5;
    localparam int     MIXED_BEATS     = 85;
    localparam int     HOLD_CYCLES     = 400;
    localparam int     CW              = eapd_pkg::COUNT_W;
    localparam int     DTW             = eapd_pkg::CFG_DATA_W;
    localparam longint COUNTS_PER_STEP = 10;
    localparam longint ANGLE_PER_STEP  = 3;
    localparam longint DRIVE_SCALE     = longint'(1) << eapd_pkg::SCALE_SHIFT;
    localparam longint RND_BIAS        = longint'(eapd_pkg::ROUND_BIAS);
    localparam longint SUM_MAX         = (longint'(1) << (eapd_pkg::SUM_W_DEF - 1)) - 1;
    localparam longint SUM_MIN         = -SUM_MAX - 1;
    localparam longint DRIVE_MAX       = (longint'(1) << (eapd_pkg::DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN       = -DRIVE_MAX - 1;
    localparam longint COUNT_MAX       = (longint'(1) << (CW - 1)) - 1;
    localparam longint COUNT_MIN       = -COUNT_MAX - 1;
    localparam logic [DTW-1:0] TGT_TOP    = 15'h3FFF;
    localparam logic [DTW-1:0] TGT_BOTTOM = 15'h4000;
    localparam logic [DTW-1:0] GAIN_ALL   = 15'h7FFF;
    localparam logic [DTW-1:0] GAIN_NONE  = 15'h7C00;
    localparam int     COUNT_CORNERS [8] = '{-32768, 32767, -1, 0, 1, -10, 10, 9};

    typedef struct packed {
        logic signed [eapd_pkg::DRIVE_W-1:0] drive;
        logic signed [eapd_pkg::ANGLE_W-1:0] angle;
        logic signed [eapd_pkg::ERR_W-1:0]   angle_error;
    } t_drive_beat;

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind          kind;
        eapd_pkg::t_cfg_idx  idx;
        logic [15:0]         arg;
        bit                  typed;
        t_drive_beat         want;
    } t_step;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    eapd_pkg::t_cfg_idx    cfg_idx  = eapd_pkg::CFG_TARGET;
    logic [DTW-1:0]        cfg_data = '0;

    eapd_in_if  smp_ch ();
    eapd_out_if res_ch ();

    // Mirror of the block's registers and loop state
    logic signed [eapd_pkg::TARGET_W-1:0]  target_q;
    logic        [eapd_pkg::GAIN_W-1:0]    prop_q;
    logic        [eapd_pkg::GAIN_W-1:0]    integ_q;
    logic        [eapd_pkg::GAIN_W-1:0]    deriv_q;
    logic signed [eapd_pkg::ERR_W-1:0]     prev_err_q;
    logic signed [eapd_pkg::SUM_W_DEF-1:0] err_sum_q;

    t_drive_beat drive_due [$];
    t_drive_beat due_head;
    t_step       dir_tab [DIR_ROWS];

    int  cycle_cnt  = 0;
    int  mismatches = 0;
    int  beats_in   = 0;
    int  beats_out  = 0;
    int  reg_writes = 0;
    int  hold_req   = 0;
    int  hold_left  = 0;
    int  stall_left = 0;
    bit  calm       = 1'b0;
    bit  sum_hit_hi = 1'b0;
    bit  sum_hit_lo = 1'b0;
    longint last_count = 0;

    encoder_angle_pid_drive uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_sample   (smp_ch),
        .o_result   (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // Guard against a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Run stopped at cycle limit %0d", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 40))
                                           : int'($urandom_range(1, 3));
    endfunction

    // Gap after a sample beat: none, an idle stretch, or drain the pipeline
    function automatic int pick_rest();
        if (calm)
            return 0;
        // keep offering while the receiver holds off, so the block fills
        if (hold_req > 0 || hold_left > 0)
            return $urandom_range(0, 1) ? 0 : idle_len();
        if ($urandom_range(0, 99) == 0)
            return -1;
        return $urandom_range(0, 1) ? 0 : idle_len();
    endfunction

    // Work out drive, angle and error for one count and advance the loop state
    function automatic t_drive_beat predict_drive(input logic signed [CW-1:0] count);
        longint      ang;
        longint      e;
        longint      d;
        longint      s;
        longint      drv;
        t_drive_beat beat;
        ang = (longint'(count) / COUNTS_PER_STEP) * ANGLE_PER_STEP;
        e   = longint'(target_q) - ang;
        d   = e - longint'(prev_err_q);
        s   = longint'(err_sum_q) + e;
        if (s > SUM_MAX)
            s = SUM_MAX;
        else if (s < SUM_MIN)
            s = SUM_MIN;
        if (s == SUM_MAX)
            sum_hit_hi = 1'b1;
        if (s == SUM_MIN)
            sum_hit_lo = 1'b1;
        if (e > 0) begin
            drv = (longint'(prop_q) * e + longint'(deriv_q) * d
                   + (RND_BIAS + longint'(integ_q) * s) / DRIVE_SCALE + RND_BIAS)
                  / DRIVE_SCALE;
        end else begin
            drv = -((longint'(prop_q) * magnitude(e) + longint'(deriv_q) * magnitude(d)
                     + (RND_BIAS + longint'(integ_q) * magnitude(s)) / DRIVE_SCALE
                     + RND_BIAS) / DRIVE_SCALE);
        end
        if (drv > DRIVE_MAX)
            drv = DRIVE_MAX;
        else if (drv < DRIVE_MIN)
            drv = DRIVE_MIN;
        err_sum_q        = eapd_pkg::SUM_W_DEF'(s);
        prev_err_q       = eapd_pkg::ERR_W'(e);
        beat.drive       = eapd_pkg::DRIVE_W'(drv);
        beat.angle       = eapd_pkg::ANGLE_W'(ang);
        beat.angle_error = eapd_pkg::ERR_W'(e);
        return beat;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_cnt, msg);
        mismatches++;
    endtask

    task automatic wait_drained();
        while (drive_due.size() != 0)
            @(posedge clk);
    endtask

    // Offer one count; rest > 0 idles, rest < 0 waits for every result
    task automatic send_beat(input logic signed [CW-1:0] count, input int rest,
                             input bit typed, input t_drive_beat want);
        t_drive_beat calc;
        smp_ch.valid         <= 1'b1;
        smp_ch.encoder_count <= count;
        do @(posedge clk); while (!smp_ch.ready);
        calc = predict_drive(count);
        drive_due.push_back(typed ? want : calc);
        beats_in++;
        if (rest != 0) begin
            smp_ch.valid <= 1'b0;
            if (rest < 0)
                wait_drained();
            else
                repeat (rest) @(posedge clk);
        end
    endtask

    // Write one register once the block has gone quiet
    task automatic cfg_write(input eapd_pkg::t_cfg_idx idx, input logic [DTW-1:0] data);
        smp_ch.valid <= 1'b0;
        wait_drained();
        repeat (IDLE_PAD) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            eapd_pkg::CFG_TARGET: target_q = data[eapd_pkg::TARGET_W-1:0];
            eapd_pkg::CFG_PROP:   prop_q   = data[eapd_pkg::GAIN_W-1:0];
            eapd_pkg::CFG_INTEG:  integ_q  = data[eapd_pkg::GAIN_W-1:0];
            eapd_pkg::CFG_DERIV:  deriv_q  = data[eapd_pkg::GAIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Random counts: tracking the target, walking, corners and noise
    task automatic run_mixed(input int n);
        longint raw;
        int     jig;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 9: raw = longint'($signed(CW'($urandom)));
                2, 3, 4, 5: begin
                    jig = $urandom_range(0, 120);
                    raw = longint'(target_q) * COUNTS_PER_STEP / ANGLE_PER_STEP + jig - 60;
                end
                6, 7: begin
                    jig = $urandom_range(0, 400);
                    raw = last_count + jig - 200;
                end
                default: raw = COUNT_CORNERS[$urandom_range(0, 7)];
            endcase
            if (raw > COUNT_MAX)
                raw = COUNT_MAX;
            else if (raw < COUNT_MIN)
                raw = COUNT_MIN;
            last_count = raw;
            send_beat(CW'(raw), pick_rest(), 1'b0, '0);
        end
    endtask

    // Hold the error at one sign until the accumulator sits at its limit
    task automatic run_push(input bit upward);
        longint raw;
        int     jig;
        int     extra;
        extra = 0;
        while (extra < 25) begin
            jig = $urandom_range(0, 1500);
            raw = upward ? COUNT_MIN + jig : COUNT_MAX - jig;
            send_beat(CW'(raw), pick_rest(), 1'b0, '0);
            if (longint'(err_sum_q) == (upward ? SUM_MAX : SUM_MIN))
                extra++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = idle_len() - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            beats_out++;
            if (drive_due.size() == 0) begin
                flag_mismatch($sformatf("result beat %0d with nothing expected (drive %0d)",
                                        beats_out, res_ch.drive));
            end else begin
                due_head = drive_due.pop_front();
                if (res_ch.drive !== due_head.drive)
                    flag_mismatch($sformatf("beat %0d drive %0d, expected %0d",
                                            beats_out, res_ch.drive, due_head.drive));
                if (res_ch.angle !== due_head.angle)
                    flag_mismatch($sformatf("beat %0d angle %0d, expected %0d",
                                            beats_out, res_ch.angle, due_head.angle));
                if (res_ch.angle_error !== due_head.angle_error)
                    flag_mismatch($sformatf("beat %0d angle_error %0d, expected %0d",
                                            beats_out, res_ch.angle_error,
                                            due_head.angle_error));
            end
        end
    end

    initial begin
        logic [DTW-1:0] tgt;
        logic [DTW-1:0] kp;
        logic [DTW-1:0] ki;
        logic [DTW-1:0] kd;

        smp_ch.valid         = 1'b0;
        smp_ch.encoder_count = '0;
        res_ch.ready         = 1'b0;

        target_q   = eapd_pkg::TARGET_RESET;
        prop_q     = '0;
        integ_q    = '0;
        deriv_q    = '0;
        prev_err_q = '0;
        err_sum_q  = '0;

        // Directed rows: reset values, extremes, masking of gain writes, zero error
        dir_tab = '{
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h0000, 1'b1, '{20'sd0, 15'sd0, 16'sd90}},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'd300,  1'b1, '{20'sd0, 15'sd90, 16'sd0}},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h7FFF, 1'b1,
              '{20'sd0, 15'sd9828, -16'sd9738}},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h8000, 1'b1,
              '{20'sd0, -15'sd9828, 16'sd9918}},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'd9,    1'b1, '{20'sd0, 15'sd0, 16'sd90}},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, -16'sd19, 1'b1, '{20'sd0, -15'sd3, 16'sd93}},
            '{STEP_WRITE,  eapd_pkg::CFG_PROP,   {1'b0, GAIN_ALL}, 1'b0, '0},
            '{STEP_WRITE,  eapd_pkg::CFG_INTEG,  {1'b0, GAIN_ALL}, 1'b0, '0},
            '{STEP_WRITE,  eapd_pkg::CFG_DERIV,  {1'b0, GAIN_ALL}, 1'b0, '0},
            '{STEP_WRITE,  eapd_pkg::CFG_TARGET, {1'b0, TGT_TOP},  1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h8000, 1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h8000, 1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h7FFF, 1'b0, '0},
            '{STEP_WRITE,  eapd_pkg::CFG_TARGET, {1'b0, TGT_BOTTOM}, 1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h7FFF, 1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h8000, 1'b0, '0},
            '{STEP_WRITE,  eapd_pkg::CFG_TARGET, 16'h0000, 1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'h0000, 1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'd10,   1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, -16'sd10, 1'b0, '0},
            '{STEP_WRITE,  eapd_pkg::CFG_PROP,   {1'b0, GAIN_NONE}, 1'b0, '0},
            '{STEP_WRITE,  eapd_pkg::CFG_INTEG,  {1'b0, GAIN_NONE}, 1'b0, '0},
            '{STEP_WRITE,  eapd_pkg::CFG_DERIV,  {1'b0, GAIN_NONE}, 1'b0, '0},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'd12345, 1'b1,
              '{20'sd0, 15'sd3702, -16'sd3702}},
            '{STEP_SAMPLE, eapd_pkg::CFG_TARGET, 16'hFFFF, 1'b1, '{20'sd0, 15'sd0, 16'sd0}}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].kind == STEP_WRITE)
                cfg_write(dir_tab[k].idx, dir_tab[k].arg[DTW-1:0]);
            else
                send_beat(dir_tab[k].arg, pick_rest(), dir_tab[k].typed, dir_tab[k].want);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < MIXED_PHASES; ph++) begin
            tgt = DTW'($urandom);
            kp  = DTW'($urandom);
            ki  = DTW'($urandom);
            kd  = DTW'($urandom);
            case (ph)
                0: begin
                    kp = GAIN_ALL;
                    ki = GAIN_ALL;
                    kd = GAIN_ALL;
                end
                1: begin
                    tgt = TGT_BOTTOM;
                    kp  = GAIN_NONE;
                    ki  = GAIN_NONE;
                    kd  = GAIN_NONE;
                end
                2: tgt = DTW'(int'($urandom_range(0, 6666)) * 3 - 9999);
                default: ;
            endcase
            cfg_write(eapd_pkg::CFG_TARGET, tgt);
            cfg_write(eapd_pkg::CFG_PROP, kp);
            cfg_write(eapd_pkg::CFG_INTEG, ki);
            cfg_write(eapd_pkg::CFG_DERIV, kd);
            // no idling on either side in one phase, a long receiver hold in another
            calm = (ph == 1);
            if (ph == 2)
                hold_req = HOLD_CYCLES;
            run_mixed(MIXED_BEATS);
            calm = 1'b0;
        end

        // Saturate the accumulator high, then swing it to the low limit
        cfg_write(eapd_pkg::CFG_TARGET, TGT_TOP);
        cfg_write(eapd_pkg::CFG_PROP, DTW'($urandom));
        cfg_write(eapd_pkg::CFG_INTEG, DTW'($urandom));
        cfg_write(eapd_pkg::CFG_DERIV, DTW'($urandom));
        run_push(1'b1);
        cfg_write(eapd_pkg::CFG_TARGET, TGT_BOTTOM);
        cfg_write(eapd_pkg::CFG_INTEG, GAIN_ALL);
        run_push(1'b0);

        smp_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_PAD) @(posedge clk);

        $display("Sent %0d samples and checked %0d results over %0d register writes.",
                 beats_in, beats_out, reg_writes);
        $display("Accumulator held at upper limit: %0s, at lower limit: %0s.",
                 sum_hit_hi ? "yes" : "no", sum_hit_lo ? "yes" : "no");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
